>>> rtl/mrf_pkg.sv
// Shared types and constants of the message ring FIFO.
package mrf_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_LONG = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // Progress of the send that is being received.
    typedef enum logic [1:0] {
        SS_IDLE     = 2'd0,
        SS_OPEN     = 2'd1,
        SS_REJ_LEN  = 2'd2,
        SS_REJ_FULL = 2'd3
    } t_send_state;

    // Byte address of the sender id register.
    localparam logic [1:0] ADDR_MODULE_ID = 2'd0;

    // Largest receive buffer; larger requests saturate to it.
    localparam logic [6:0] RECV_CAP_MAX = 7'd64;

    // Reset value of the sender id register.
    localparam logic [7:0] MODULE_ID_RESET = 8'd1;

    // One input beat.
    typedef struct packed {
        logic       mode;
        logic [7:0] msg_kind;
        logic [7:0] msg_length;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [6:0] recv_capacity;
    } t_in;

    // One result beat.
    typedef struct packed {
        t_status    status;
        logic [7:0] src_id;
        logic [7:0] type_out;
        logic [6:0] length_out;
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       last_result;
    } t_out;

    // Stored message header.
    typedef struct packed {
        logic [7:0] src_id;
        logic [7:0] msg_kind;
        logic [7:0] msg_length;
    } t_hdr;

endpackage

>>> rtl/message_ring_fifo.sv
// Top level of the message ring FIFO: header and payload memories and their control.
//
// Usage: an item on i_cmd is accepted at a rising edge with start high and busy low.
// A send delivers one payload beat per item; its final item (last_byte, or the first
// item of a zero-length send) yields one status result in the next cycle. Send items
// are taken every cycle while busy is low and never raise busy.
// A receive request yields, in the next cycle, a queue-empty status when the ring is
// empty. Otherwise the header memory is read in the accept cycle, the header is
// evaluated in the next cycle, and the payload bytes then stream one per cycle from
// the payload memory, each on o_result for exactly one cycle with o_result_valid.
// After the accept the receive passes through RX_HDR and then RX_STREAM, and each
// byte is shown from the payload read register; busy is high in RX_HDR and RX_STREAM
// (in RX_HDR alone when nothing is copied).
// The receiver cannot stall: each result beat is taken in the cycle it is shown.
// Reset empties the ring, closes any open send and sets module_id to 1; the memories
// are not cleared and need no clearing pass. The user must write module_id over the
// APB port (pready is always high) only while the block is idle; this is not enforced.
module message_ring_fifo
    import mrf_pkg::*;
#(
    parameter int QUEUE_SLOTS = 64,
    parameter int MAX_PAYLOAD = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command channel
    input  logic        start,
    output logic        busy,
    input  t_in         i_cmd,
    // Result channel
    output logic        o_result_valid,
    output t_out        o_result,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW        = $clog2(QUEUE_SLOTS);
    localparam int IW        = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CW        = $clog2(MAX_PAYLOAD + 1);
    localparam int PAY_DEPTH = QUEUE_SLOTS * (2 ** IW);
    localparam logic [SW-1:0] LAST_SLOT = SW'(QUEUE_SLOTS - 1);
    localparam logic [7:0]    LEN_MAX   = 8'(MAX_PAYLOAD);

    typedef enum logic [1:0] {
        RX_IDLE,
        RX_HDR,
        RX_STREAM
    } t_rx_state;

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
        next_slot = (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    // Memories
    t_hdr       mem_header [QUEUE_SLOTS];
    logic [7:0] mem_payload [PAY_DEPTH];

    // Control registers and their next values
    t_rx_state   r_rx_state, n_rx_state;
    t_send_state r_send_state, n_send_state;
    logic [SW-1:0] r_write_slot, n_write_slot;
    logic [SW-1:0] r_read_slot, n_read_slot;
    logic [CW-1:0] r_byte_count, n_byte_count;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_rd_n, n_rd_n;
    logic          r_out_valid, n_out_valid;
    logic          r_rd_valid, n_rd_valid;
    logic [7:0]    r_module_id;

    // Payload registers
    logic [7:0]    r_send_len, n_send_len;
    logic [6:0]    r_cap, n_cap;
    logic [SW-1:0] r_rs_cur, n_rs_cur;
    t_hdr          r_cur_hdr, n_cur_hdr;
    logic          r_rd_last, n_rd_last;
    t_out          r_out, n_out;
    t_hdr          r_hdr_q;
    logic [7:0]    r_pay_q;

    // Handshake decode
    logic accept, send_acc, recv_acc;
    logic ring_empty, ring_full;

    // Send path
    logic          send_first, send_ends, store_byte;
    t_send_state   open_state;
    logic [7:0]    send_dlen;
    logic [CW-1:0] send_cnt;
    logic          hdr_wr_en, pay_wr_en;
    t_status       send_status;

    // Receive path
    logic [7:0]       copy_min, copy_n;
    logic [SW+IW-1:0] pay_waddr, pay_raddr;

    assign busy       = (r_rx_state != RX_IDLE);
    assign accept     = start && !busy;
    assign send_acc   = accept && !i_cmd.mode;
    assign recv_acc   = accept && i_cmd.mode;
    assign ring_empty = (r_read_slot == r_write_slot);
    assign ring_full  = (next_slot(r_write_slot) == r_read_slot);

    // The first item of a send decides whether it is stored or rejected.
    always_comb begin
        send_first = (r_send_state == SS_IDLE);
        if (!send_first) begin
            open_state = r_send_state;
        end else if (i_cmd.msg_length > LEN_MAX) begin
            open_state = SS_REJ_LEN;
        end else if (ring_full) begin
            open_state = SS_REJ_FULL;
        end else begin
            open_state = SS_OPEN;
        end
        send_dlen  = send_first ? i_cmd.msg_length : r_send_len;
        send_cnt   = send_first ? '0 : r_byte_count;
        store_byte = (open_state == SS_OPEN) && (8'(send_cnt) < send_dlen);
        send_ends  = i_cmd.last_byte || (send_first && (i_cmd.msg_length == 8'd0));
        hdr_wr_en  = send_acc && send_first && (open_state == SS_OPEN);
        pay_wr_en  = send_acc && store_byte;
        pay_waddr  = {r_write_slot, send_cnt[IW-1:0]};
        case (open_state)
            SS_REJ_LEN:  send_status = ST_TOO_LONG;
            SS_REJ_FULL: send_status = ST_FULL;
            default:     send_status = ST_OK;
        endcase
    end

    // Number of bytes copied: capacity, stored length and slot size, whichever is least.
    always_comb begin
        copy_min  = ({1'b0, r_cap} < r_hdr_q.msg_length) ? {1'b0, r_cap} : r_hdr_q.msg_length;
        copy_n    = (copy_min > LEN_MAX) ? LEN_MAX : copy_min;
        pay_raddr = {r_rs_cur, r_rd_idx[IW-1:0]};
    end

    // Next state of the send and receive control.
    always_comb begin
        n_rx_state   = r_rx_state;
        n_send_state = r_send_state;
        n_write_slot = r_write_slot;
        n_read_slot  = r_read_slot;
        n_byte_count = r_byte_count;
        n_rd_idx     = r_rd_idx;
        n_rd_n       = r_rd_n;
        n_out_valid  = 1'b0;
        n_rd_valid   = 1'b0;
        n_send_len   = r_send_len;
        n_cap        = r_cap;
        n_rs_cur     = r_rs_cur;
        n_cur_hdr    = r_cur_hdr;
        n_rd_last    = r_rd_last;
        n_out        = r_out;

        // Send beat
        if (send_acc) begin
            if (send_ends) begin
                if (open_state == SS_OPEN) begin
                    n_write_slot = next_slot(r_write_slot);
                end
                n_send_state = SS_IDLE;
                n_byte_count = '0;
                n_out_valid  = 1'b1;
                n_out        = '{status: send_status, src_id: 8'd0, type_out: 8'd0,
                                 length_out: 7'd0, byte_out: 8'd0, byte_valid: 1'b0,
                                 last_result: 1'b1};
            end else begin
                n_send_state = open_state;
                n_byte_count = store_byte ? send_cnt + 1'b1 : send_cnt;
            end
            if (send_first) begin
                n_send_len = i_cmd.msg_length;
            end
        end

        // Receive sequencer
        case (r_rx_state)
            RX_IDLE: begin
                if (recv_acc) begin
                    if (ring_empty) begin
                        n_out_valid = 1'b1;
                        n_out       = '{status: ST_EMPTY, src_id: 8'd0, type_out: 8'd0,
                                        length_out: 7'd0, byte_out: 8'd0, byte_valid: 1'b0,
                                        last_result: 1'b1};
                    end else begin
                        n_cap      = (i_cmd.recv_capacity > RECV_CAP_MAX) ?
                                     RECV_CAP_MAX : i_cmd.recv_capacity;
                        n_rx_state = RX_HDR;
                    end
                end
            end
            RX_HDR: begin
                n_cur_hdr   = r_hdr_q;
                n_rs_cur    = r_read_slot;
                n_read_slot = next_slot(r_read_slot);
                n_rd_idx    = '0;
                n_rd_n      = CW'(copy_n);
                if (copy_n == 8'd0) begin
                    n_out_valid = 1'b1;
                    n_out       = '{status: ST_OK, src_id: r_hdr_q.src_id,
                                    type_out: r_hdr_q.msg_kind,
                                    length_out: r_hdr_q.msg_length[6:0], byte_out: 8'd0,
                                    byte_valid: 1'b0, last_result: 1'b1};
                    n_rx_state  = RX_IDLE;
                end else begin
                    n_rx_state = RX_STREAM;
                end
            end
            RX_STREAM: begin
                n_rd_valid = 1'b1;
                n_rd_last  = ((r_rd_idx + 1'b1) == r_rd_n);
                n_rd_idx   = r_rd_idx + 1'b1;
                if (n_rd_last) begin
                    n_rx_state = RX_IDLE;
                end
            end
            default: begin
                n_rx_state = RX_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_state   <= RX_IDLE;
            r_send_state <= SS_IDLE;
            r_write_slot <= '0;
            r_read_slot  <= '0;
            r_byte_count <= '0;
            r_rd_idx     <= '0;
            r_rd_n       <= '0;
            r_out_valid  <= 1'b0;
            r_rd_valid   <= 1'b0;
        end else begin
            r_rx_state   <= n_rx_state;
            r_send_state <= n_send_state;
            r_write_slot <= n_write_slot;
            r_read_slot  <= n_read_slot;
            r_byte_count <= n_byte_count;
            r_rd_idx     <= n_rd_idx;
            r_rd_n       <= n_rd_n;
            r_out_valid  <= n_out_valid;
            r_rd_valid   <= n_rd_valid;
        end
        r_send_len <= n_send_len;
        r_cap      <= n_cap;
        r_rs_cur   <= n_rs_cur;
        r_cur_hdr  <= n_cur_hdr;
        r_rd_last  <= n_rd_last;
        r_out      <= n_out;
    end

    // Header memory: written when a send opens, read at the head slot every cycle.
    always_ff @(posedge i_clk) begin
        if (hdr_wr_en) begin
            mem_header[r_write_slot] <= '{src_id: r_module_id, msg_kind: i_cmd.msg_kind,
                                         msg_length: i_cmd.msg_length};
        end
        r_hdr_q <= mem_header[r_read_slot];
    end

    // Payload memory: one write port for send beats, one read port for the stream.
    always_ff @(posedge i_clk) begin
        if (pay_wr_en) begin
            mem_payload[pay_waddr] <= i_cmd.data_byte;
        end
        r_pay_q <= mem_payload[pay_raddr];
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_module_id <= MODULE_ID_RESET;
        end else if (psel && penable && pwrite && pready) begin
            r_module_id <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MODULE_ID) ? {24'd0, r_module_id} : 32'd0;

    // Result mux: streamed bytes come straight from the payload read register.
    assign o_result_valid = r_out_valid || r_rd_valid;
    always_comb begin
        if (r_rd_valid) begin
            o_result = '{status: ST_OK, src_id: r_cur_hdr.src_id,
                         type_out: r_cur_hdr.msg_kind,
                         length_out: r_cur_hdr.msg_length[6:0], byte_out: r_pay_q,
                         byte_valid: 1'b1, last_result: r_rd_last};
        end else begin
            o_result = r_out;
        end
    end

    // A status result and a streamed byte never compete for the result port.
    a_no_result_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_out_valid && r_rd_valid))
        else $error("status result and streamed byte in the same cycle");

    // The stream index stays below the copy count.
    a_stream_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rx_state == RX_STREAM) |-> (r_rd_idx < r_rd_n))
        else $error("stream index ran past the copy count");

    // A receive on an empty ring answers with queue empty in the next cycle.
    a_empty_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (recv_acc && ring_empty) |=>
        (o_result_valid && (o_result.status == ST_EMPTY) && o_result.last_result))
        else $error("empty receive gave no queue-empty result");

    // Committing a send never makes the ring look empty.
    a_commit_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_write_slot != $past(r_write_slot) && $past(i_rst_n)) |-> !ring_empty)
        else $error("write slot caught up with the read slot");

    // The last streamed byte closes the receive.
    a_stream_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_valid && r_rd_last) |-> (r_rx_state == RX_IDLE))
        else $error("final byte streamed while the receive is still open");

endmodule
